@@ hdl/pffp_pkg.sv @@
// ----------------------------------------------------------------------------
// pffp_pkg
// Shared types, codes and helpers for the panel frame field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pffp_pkg;

    // header length in bytes, 1 to 8
    localparam int HEADER_LENGTH = 4;

    localparam int CHAR_W    = 8;
    localparam int VOLT_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int BITPOS_W  = 18;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_CHAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_POSITIONS  = 3'd3;

    // reset values of the registers
    localparam logic [31:0]         HEADER_RESET     = 32'h2442_5554;
    localparam logic [CHAR_W-1:0]   SEPARATOR_RESET  = 8'h2C;
    localparam logic [CHAR_W-1:0]   TERMINATOR_RESET = 8'h2A;
    localparam logic [BITPOS_W-1:0] BITPOS_RESET     = 18'h2C688;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // button bit groups inside bit_positions
    localparam int GRP_VISIBLE = 0;
    localparam int GRP_THERMAL = 1;
    localparam int GRP_TRACK   = 2;
    localparam int GRP_STAB    = 3;
    localparam int GRP_LASER   = 4;
    localparam int GRP_TRIGGER = 5;

    // decoded output codes
    localparam logic [1:0] CAM_NONE    = 2'd0;
    localparam logic [1:0] CAM_VISIBLE = 2'd1;
    localparam logic [1:0] CAM_THERMAL = 2'd2;
    localparam logic [1:0] MOV_MANUAL  = 2'd0;
    localparam logic [1:0] MOV_TRACK   = 2'd1;
    localparam logic [1:0] MOV_STAB    = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_PRESEP = 5'b00100,
        PH_BUTTON = 5'b01000,
        PH_VOLT   = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        SCAN_WS     = 3'b001,
        SCAN_DIGITS = 3'b010,
        SCAN_DONE   = 3'b100
    } scan_t;

    typedef struct packed {
        logic              frame_accepted;
        logic [7:0]        button_byte;
        logic [VOLT_W-1:0] voltage_value;
        logic [1:0]        camera_select;
        logic [1:0]        movement_mode;
        logic              laser_power;
        logic              trigger_enable;
    } res_t;

    // header byte i, first byte in the top position, zero beyond the word
    function automatic logic [CHAR_W-1:0] header_byte(input logic [31:0] word,
                                                      input logic [2:0]  idx);
        logic [CHAR_W-1:0] b;
        int                pos;
        b   = '0;
        pos = HEADER_LENGTH - 1 - int'(idx);
        if (int'(idx) < HEADER_LENGTH && pos < 4)
        begin
            b = word[8*pos +: 8];
        end
        return b;
    endfunction

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [3:0] v;
        v = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            v = 4'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_LA && c <= CHAR_LF)
        begin
            v = 4'(c - CHAR_LA + 8'd10);
        end
        else if (c >= CHAR_UA && c <= CHAR_UF)
        begin
            v = 4'(c - CHAR_UA + 8'd10);
        end
        return v;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic button_bit(input logic [7:0]          b,
                                        input logic [BITPOS_W-1:0] bp,
                                        input int                  grp);
        logic [2:0] pos;
        pos = bp[3*grp +: 3];
        return b[pos];
    endfunction

endpackage

`default_nettype wire

@@ hdl/pffp_if.sv @@
// ----------------------------------------------------------------------------
// pffp channel interfaces
// Character input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pffp_char_if;
    import pffp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;
    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface pffp_result_if;
    import pffp_pkg::*;
    logic              valid;
    logic              ready;
    logic              frame_accepted;
    logic [7:0]        button_byte;
    logic [VOLT_W-1:0] voltage_value;
    logic [1:0]        camera_select;
    logic [1:0]        movement_mode;
    logic              laser_power;
    logic              trigger_enable;
    modport source (output valid, output frame_accepted, output button_byte,
                    output voltage_value, output camera_select, output movement_mode,
                    output laser_power, output trigger_enable, input ready);
    modport sink   (input valid, input frame_accepted, input button_byte,
                    input voltage_value, input camera_select, input movement_mode,
                    input laser_power, input trigger_enable, output ready);
endinterface

interface pffp_cfg_if;
    import pffp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/panel_frame_field_parser.sv @@
// ----------------------------------------------------------------------------
// panel_frame_field_parser
// Parses control panel frames from a character stream, one character a cycle while rx.ready is high.
// ----------------------------------------------------------------------------
// usage
//   rx  : one received character per transfer (rx_char)
//   res : one result per character; frame_accepted marks the character that
//         closed a good frame, the other fields show the held button byte,
//         held voltage and the camera, movement, laser and trigger decode
//   cfg : register writes (header word, separator, terminator, bit positions),
//         always ready, to be used only while the parser is idle
// result: registered in out_reg, or in the skid entry while res is stalled
// throughput: one character per cycle; the parser state is updated in the
//   same cycle as the transfer, so each character sees the previous one's state
// the result register is backed by one skid entry, so one more character is
//   taken while a result waits; with both full, rx.ready drops until res drains
// reset: registers return to "$BUT", ',' and '*', bit positions 0..5, the
//   parser goes idle and the held button byte and voltage read zero
// ----------------------------------------------------------------------------
`default_nettype none

module panel_frame_field_parser
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    pffp_char_if.sink    rx,
    pffp_result_if.source res,
    pffp_cfg_if.sink     cfg
);
    import pffp_pkg::*;

    // configuration registers
    logic [31:0]         header_word_reg;
    logic [CHAR_W-1:0]   separator_reg;
    logic [CHAR_W-1:0]   terminator_reg;
    logic [BITPOS_W-1:0] bit_positions_reg;

    // parser state
    phase_t            phase_reg,        phase_next;
    logic [2:0]        header_index_reg, header_index_next;
    logic              header_match_reg, header_match_next;
    logic [3:0]        hex_first_reg,    hex_first_next;
    logic [3:0]        hex_second_reg,   hex_second_next;
    logic [1:0]        hex_count_reg,    hex_count_next;
    logic [VOLT_W-1:0] dec_acc_reg,      dec_acc_next;
    logic              dec_neg_reg,      dec_neg_next;
    scan_t             scan_reg,         scan_next;
    logic [7:0]        held_button_reg,  held_button_next;
    logic [VOLT_W-1:0] held_voltage_reg, held_voltage_next;

    // output register and skid entry
    res_t out_reg;
    logic out_valid_reg;
    res_t skid_reg;
    logic skid_valid_reg;

    logic              rx_fire;
    logic              out_free;
    logic              accepted;
    logic [CHAR_W-1:0] c;
    logic              is_digit;
    logic [3:0]        digit_val;
    logic [VOLT_W-1:0] acc_times_ten;
    logic [2:0]        header_index_inc;
    res_t              res_new;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !skid_valid_reg;
    assign rx_fire   = rx.valid && rx.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign c             = rx.rx_char;
    assign is_digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign digit_val     = 4'(c - CHAR_ZERO);
    // acc * 10 as two shifts, wrapping at 16 bits
    assign acc_times_ten = VOLT_W'({dec_acc_reg, 3'b000} + {dec_acc_reg, 1'b0});
    assign header_index_inc = header_index_reg + 3'd1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_word_reg   <= HEADER_RESET;
            separator_reg     <= SEPARATOR_RESET;
            terminator_reg    <= TERMINATOR_RESET;
            bit_positions_reg <= BITPOS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_HEADER_WORD:    header_word_reg   <= cfg.data;
                REG_SEPARATOR_CHAR: separator_reg     <= cfg.data[CHAR_W-1:0];
                REG_TERMINATOR:     terminator_reg    <= cfg.data[CHAR_W-1:0];
                REG_BIT_POSITIONS:  bit_positions_reg <= cfg.data[BITPOS_W-1:0];
                default:            ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // next parser state for the character in transfer
    always_comb
    begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        header_match_next = header_match_reg;
        hex_first_next    = hex_first_reg;
        hex_second_next   = hex_second_reg;
        hex_count_next    = hex_count_reg;
        dec_acc_next      = dec_acc_reg;
        dec_neg_next      = dec_neg_reg;
        scan_next         = scan_reg;
        held_button_next  = held_button_reg;
        held_voltage_next = held_voltage_reg;
        accepted          = 1'b0;

        if (rx_fire)
        begin
            if (c == header_byte(header_word_reg, 3'd0))
            begin
                // first header byte always restarts the frame
                header_match_next = 1'b0;
                hex_first_next    = '0;
                hex_second_next   = '0;
                hex_count_next    = '0;
                dec_acc_next      = '0;
                dec_neg_next      = 1'b0;
                scan_next         = SCAN_WS;
                header_index_next = 3'd1;
                if (HEADER_LENGTH <= 1)
                begin
                    header_match_next = 1'b1;
                    phase_next        = PH_PRESEP;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            else if (c == terminator_reg)
            begin
                if (phase_reg == PH_VOLT && header_match_reg)
                begin
                    case (hex_count_reg)
                        2'd0:    held_button_next = 8'h00;
                        2'd1:    held_button_next = {4'h0, hex_first_reg};
                        default: held_button_next = {hex_first_reg, hex_second_reg};
                    endcase
                    held_voltage_next = dec_neg_reg ? VOLT_W'(-dec_acc_reg) : dec_acc_reg;
                    accepted          = 1'b1;
                end
                phase_next = PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_HEADER:
                    begin
                        if (c == header_byte(header_word_reg, header_index_reg))
                        begin
                            header_index_next = header_index_inc;
                            if ({1'b0, header_index_inc} >= 4'(HEADER_LENGTH)
                                || header_index_inc == 3'd0)
                            begin
                                header_match_next = 1'b1;
                                phase_next        = PH_PRESEP;
                            end
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_PRESEP:
                    begin
                        if (c == separator_reg)
                        begin
                            phase_next = PH_BUTTON;
                        end
                    end
                    PH_BUTTON:
                    begin
                        if (c == separator_reg)
                        begin
                            phase_next = PH_VOLT;
                        end
                        else if (hex_count_reg == 2'd0)
                        begin
                            hex_first_next = hex_value(c);
                            hex_count_next = 2'd1;
                        end
                        else if (hex_count_reg == 2'd1)
                        begin
                            hex_second_next = hex_value(c);
                            hex_count_next  = 2'd2;
                        end
                    end
                    PH_VOLT:
                    begin
                        // atol style scan: blanks, one sign, digits
                        unique case (scan_reg)
                            SCAN_WS:
                            begin
                                if (is_space(c))
                                begin
                                end
                                else if (c == CHAR_PLUS || c == CHAR_MINUS)
                                begin
                                    dec_neg_next = (c == CHAR_MINUS);
                                    scan_next    = SCAN_DIGITS;
                                end
                                else if (is_digit)
                                begin
                                    scan_next    = SCAN_DIGITS;
                                    dec_acc_next = acc_times_ten + VOLT_W'(digit_val);
                                end
                                else
                                begin
                                    scan_next = SCAN_DONE;
                                end
                            end
                            SCAN_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    dec_acc_next = acc_times_ten + VOLT_W'(digit_val);
                                end
                                else
                                begin
                                    scan_next = SCAN_DONE;
                                end
                            end
                            SCAN_DONE:
                            begin
                            end
                            default:
                            begin
                                scan_next = SCAN_DONE;
                            end
                        endcase
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result for this character, decoded from the updated held button byte
    always_comb
    begin
        res_new.frame_accepted = accepted;
        res_new.button_byte    = held_button_next;
        res_new.voltage_value  = held_voltage_next;
        if (button_bit(held_button_next, bit_positions_reg, GRP_VISIBLE))
        begin
            res_new.camera_select = CAM_VISIBLE;
        end
        else if (button_bit(held_button_next, bit_positions_reg, GRP_THERMAL))
        begin
            res_new.camera_select = CAM_THERMAL;
        end
        else
        begin
            res_new.camera_select = CAM_NONE;
        end
        if (button_bit(held_button_next, bit_positions_reg, GRP_TRACK))
        begin
            res_new.movement_mode = MOV_TRACK;
        end
        else if (button_bit(held_button_next, bit_positions_reg, GRP_STAB))
        begin
            res_new.movement_mode = MOV_STAB;
        end
        else
        begin
            res_new.movement_mode = MOV_MANUAL;
        end
        res_new.laser_power    = button_bit(held_button_next, bit_positions_reg, GRP_LASER);
        res_new.trigger_enable = button_bit(held_button_next, bit_positions_reg, GRP_TRIGGER);
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            header_index_reg <= '0;
            header_match_reg <= 1'b0;
            hex_first_reg    <= '0;
            hex_second_reg   <= '0;
            hex_count_reg    <= '0;
            dec_acc_reg      <= '0;
            dec_neg_reg      <= 1'b0;
            scan_reg         <= SCAN_WS;
            held_button_reg  <= '0;
            held_voltage_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            header_match_reg <= header_match_next;
            hex_first_reg    <= hex_first_next;
            hex_second_reg   <= hex_second_next;
            hex_count_reg    <= hex_count_next;
            dec_acc_reg      <= dec_acc_next;
            dec_neg_reg      <= dec_neg_next;
            scan_reg         <= scan_next;
            held_button_reg  <= held_button_next;
            held_voltage_reg <= held_voltage_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= rx_fire;
            end
        end
        else if (rx_fire)
        begin
            // result held downstream, park the new one
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        if (!out_free && rx_fire)
        begin
            skid_reg <= res_new;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.frame_accepted = out_reg.frame_accepted;
    assign res.button_byte    = out_reg.button_byte;
    assign res.voltage_value  = out_reg.voltage_value;
    assign res.camera_select  = out_reg.camera_select;
    assign res.movement_mode  = out_reg.movement_mode;
    assign res.laser_power    = out_reg.laser_power;
    assign res.trigger_enable = out_reg.trigger_enable;

endmodule

`default_nettype wire

@@ hdl/pffp_checker.sv @@
// ----------------------------------------------------------------------------
// pffp_checker
// Port level checks on the panel frame field parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pffp_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rx_valid,
    input wire logic       rx_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] res_button_byte,
    input wire logic       res_frame_accepted
);

    // a stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_button_byte)
            && $stable(res_frame_accepted))
        else $error("result changed while stalled");

    // input back-pressure only when a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> res_valid)
        else $error("input stalled with empty output");

    // full skid stays full until the output drains
    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready && !res_ready |=> !rx_ready)
        else $error("skid entry lost while output stalled");

    // a transfer into an empty output shows up the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && !res_valid |=> res_valid)
        else $error("result missing one cycle after transfer");

endmodule

bind panel_frame_field_parser pffp_checker u_pffp_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .rx_valid           (rx.valid),
    .rx_ready           (rx.ready),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_button_byte    (res.button_byte),
    .res_frame_accepted (res.frame_accepted)
);

`default_nettype wire
